[src/atp_pkg.sv]
// Shared constants, types and command/status structs for the task placement block.
`timescale 1ns / 1ps

package atp_pkg;

    localparam int NUM_NODES = 64;
    localparam int NUM_ZONES = 64;
    localparam int NUM_APPS  = 256;

    localparam int NODE_W = 6;
    localparam int ZONE_W = 6;
    localparam int APP_W  = 8;
    localparam int CNT_W  = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SCHED = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RD_AFF,
        S_RD_ANTI,
        S_RD_APP,
        S_SCAN,
        S_DRAIN,
        S_UPD,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        APP_SEL_AFF,
        APP_SEL_ANTI,
        APP_SEL_APP
    } app_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load_wr;
        logic     app_rd;
        app_sel_t app_sel;
        logic     cap_aff;
        logic     cap_anti;
        logic     scan_start;
        logic     scan_en;
        logic     update;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [NUM_NODES-1:0] node_mask;
        logic [NUM_ZONES-1:0] zone_mask;
    } app_row_t;

endpackage

[src/atp_ctrl.sv]
// Controller state machine sequencing loads, table reads, node scan and update.
`timescale 1ns / 1ps

module atp_ctrl
    import atp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       operation,
    input  logic       out_stall,
    input  dp_status_t status,
    output logic       in_stall,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == OP_SCHED) ? S_RD_AFF : S_LOAD;
                end
            end
            S_LOAD:    state_next = S_IDLE;
            S_RD_AFF:  state_next = S_RD_ANTI;
            S_RD_ANTI: state_next = S_RD_APP;
            S_RD_APP:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:   state_next = S_UPD;
            S_UPD:     state_next = S_DONE;
            S_DONE:
            begin
                if (!status.out_busy || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.app_sel = APP_SEL_AFF;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_LOAD:
            begin
                cmd.load_wr = 1'b1;
            end
            S_RD_AFF:
            begin
                cmd.app_rd  = 1'b1;
                cmd.app_sel = APP_SEL_AFF;
            end
            S_RD_ANTI:
            begin
                cmd.app_rd  = 1'b1;
                cmd.app_sel = APP_SEL_ANTI;
                cmd.cap_aff = 1'b1;
            end
            S_RD_APP:
            begin
                cmd.app_rd     = 1'b1;
                cmd.app_sel    = APP_SEL_APP;
                cmd.cap_anti   = 1'b1;
                cmd.scan_start = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.scan_en = 1'b0;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
            end
            S_DONE:
            begin
                cmd.out_load = !status.out_busy || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[src/atp_dp.sv]
// Datapath: node and application tables, filter evaluation, least-loaded trackers, result register.
`timescale 1ns / 1ps

module atp_dp
    import atp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [NODE_W-1:0] node_index,
    input  logic [ZONE_W-1:0] node_zone,
    input  logic [APP_W-1:0]  app_id,
    input  logic [ZONE_W-1:0] zone_required,
    input  logic [APP_W-1:0]  affine_app,
    input  logic [APP_W-1:0]  anti_app,
    input  logic              anti_strict,
    input  logic              group_end,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [NODE_W-1:0] chosen_node,
    output logic              group_end_res
);

    // latched item fields
    logic [NODE_W-1:0] nidx_reg;
    logic [ZONE_W-1:0] nzone_reg;
    logic [APP_W-1:0]  app_reg;
    logic [ZONE_W-1:0] zreq_reg;
    logic [APP_W-1:0]  aff_reg;
    logic [APP_W-1:0]  anti_reg;
    logic              strict_reg;
    logic              gend_reg;

    // node tables
    logic [ZONE_W-1:0] zone_mem [NUM_NODES];
    logic [CNT_W-1:0]  tasks_mem [NUM_NODES];
    logic [NUM_NODES-1:0] present_reg;
    logic [NUM_NODES-1:0] tasks_valid_reg;

    // application table
    app_row_t          app_mem [NUM_APPS];
    logic [NUM_APPS-1:0] app_valid_reg;
    app_row_t          app_rd_reg;
    logic              app_rd_vld_reg;
    logic [APP_W-1:0]  app_addr;
    logic [NUM_ZONES-1:0] aff_zone_reg;
    logic [NUM_NODES-1:0] anti_node_reg;

    // scan pipeline
    logic [NODE_W-1:0] scan_addr_reg;
    logic [NODE_W-1:0] rd_idx_reg;
    logic              rd_vld_reg;
    logic [ZONE_W-1:0] zone_rd_reg;
    logic [CNT_W-1:0]  tasks_rd_reg;
    logic              tasks_rd_vld_reg;

    // least-loaded trackers over the filtered set and over the set after anti-affinity
    logic              can_found_reg;
    logic [NODE_W-1:0] can_idx_reg;
    logic [CNT_W-1:0]  can_cnt_reg;
    logic [ZONE_W-1:0] can_zone_reg;
    logic              kept_found_reg;
    logic [NODE_W-1:0] kept_idx_reg;
    logic [CNT_W-1:0]  kept_cnt_reg;
    logic [ZONE_W-1:0] kept_zone_reg;

    logic [NODE_W-1:0] res_node_reg;
    logic              out_valid_reg;
    logic [NODE_W-1:0] chosen_node_reg;
    logic              group_end_res_reg;

    logic              load_ok;
    logic              app_in;
    logic              aff_in;
    logic              anti_in;
    logic [CNT_W-1:0]  cnt_eff;
    logic              zone_ok;
    logic              aff_ok;
    logic              cand;
    logic              kept;
    logic              can_take;
    logic              kept_take;
    logic              win_found;
    logic [NODE_W-1:0] win_idx;
    logic [CNT_W-1:0]  win_cnt;
    logic [ZONE_W-1:0] win_zone;
    app_row_t          app_base;
    app_row_t          app_new;

    assign load_ok = (nidx_reg != '0)
                  && ({1'b0, nidx_reg} < (NODE_W+1)'(NUM_NODES))
                  && ({1'b0, nzone_reg} < (ZONE_W+1)'(NUM_ZONES));
    assign app_in  = {1'b0, app_reg}  < (APP_W+1)'(NUM_APPS);
    assign aff_in  = {1'b0, aff_reg}  < (APP_W+1)'(NUM_APPS);
    assign anti_in = {1'b0, anti_reg} < (APP_W+1)'(NUM_APPS);

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            nidx_reg   <= node_index;
            nzone_reg  <= node_zone;
            app_reg    <= app_id;
            zreq_reg   <= zone_required;
            aff_reg    <= affine_app;
            anti_reg   <= anti_app;
            strict_reg <= anti_strict;
            gend_reg   <= group_end;
        end
    end

    // node zone table
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_ok)
        begin
            zone_mem[nidx_reg] <= nzone_reg;
        end
        if (cmd.scan_en)
        begin
            zone_rd_reg <= zone_mem[scan_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else if (cmd.load_wr && load_ok)
        begin
            present_reg[nidx_reg] <= 1'b1;
        end
    end

    // task count table
    always_ff @(posedge clk)
    begin
        if (cmd.update && win_found)
        begin
            tasks_mem[win_idx] <= (win_cnt == '1) ? win_cnt : win_cnt + CNT_W'(1);
        end
        if (cmd.scan_en)
        begin
            tasks_rd_reg     <= tasks_mem[scan_addr_reg];
            tasks_rd_vld_reg <= tasks_valid_reg[scan_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tasks_valid_reg <= '0;
        end
        else if (cmd.update && win_found)
        begin
            tasks_valid_reg[win_idx] <= 1'b1;
        end
    end

    // application table
    always_comb
    begin
        case (cmd.app_sel)
            APP_SEL_AFF:  app_addr = aff_reg;
            APP_SEL_ANTI: app_addr = anti_reg;
            default:      app_addr = app_reg;
        endcase
    end

    assign app_base = app_rd_vld_reg ? app_rd_reg : '0;

    always_comb
    begin
        app_new           = app_base;
        app_new.node_mask = app_base.node_mask | (NUM_NODES'(1) << win_idx);
        app_new.zone_mask = app_base.zone_mask | (NUM_ZONES'(1) << win_zone);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && win_found && app_in)
        begin
            app_mem[app_reg] <= app_new;
        end
        if (cmd.app_rd)
        begin
            app_rd_reg     <= app_mem[app_addr];
            app_rd_vld_reg <= app_valid_reg[app_addr];
        end
        if (cmd.cap_aff)
        begin
            aff_zone_reg <= (app_rd_vld_reg && aff_in) ? app_rd_reg.zone_mask : '0;
        end
        if (cmd.cap_anti)
        begin
            anti_node_reg <= (app_rd_vld_reg && anti_in && (anti_reg != '0))
                           ? app_rd_reg.node_mask : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_valid_reg <= '0;
        end
        else if (cmd.update && win_found && app_in)
        begin
            app_valid_reg[app_reg] <= 1'b1;
        end
    end

    // scan address and read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_en;
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.scan_en)
            begin
                scan_addr_reg <= scan_addr_reg + NODE_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            rd_idx_reg <= scan_addr_reg;
        end
    end

    assign status.scan_last = scan_addr_reg == NODE_W'(NUM_NODES - 1);
    assign status.out_busy  = out_valid_reg;

    // filter evaluation for the node in the read stage
    assign cnt_eff = tasks_rd_vld_reg ? tasks_rd_reg : '0;
    assign zone_ok = (zreq_reg == '0)
                  || (({1'b0, zreq_reg} < (ZONE_W+1)'(NUM_ZONES)) && (zone_rd_reg == zreq_reg));
    assign aff_ok  = (aff_reg == '0) || aff_zone_reg[zone_rd_reg];
    assign cand    = rd_vld_reg && present_reg[rd_idx_reg] && (rd_idx_reg != '0)
                  && zone_ok && aff_ok;
    assign kept    = cand && !anti_node_reg[rd_idx_reg];
    assign can_take  = cand && (!can_found_reg || (cnt_eff < can_cnt_reg));
    assign kept_take = kept && (!kept_found_reg || (cnt_eff < kept_cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            can_found_reg  <= 1'b0;
            kept_found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            can_found_reg  <= 1'b0;
            kept_found_reg <= 1'b0;
        end
        else
        begin
            if (can_take)
            begin
                can_found_reg <= 1'b1;
            end
            if (kept_take)
            begin
                kept_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take)
        begin
            can_idx_reg  <= rd_idx_reg;
            can_cnt_reg  <= cnt_eff;
            can_zone_reg <= zone_rd_reg;
        end
        if (kept_take)
        begin
            kept_idx_reg  <= rd_idx_reg;
            kept_cnt_reg  <= cnt_eff;
            kept_zone_reg <= zone_rd_reg;
        end
    end

    // fall back to the filtered set when best-effort anti-affinity leaves nothing
    always_comb
    begin
        win_found = 1'b0;
        win_idx   = '0;
        win_cnt   = '0;
        win_zone  = '0;
        if (kept_found_reg)
        begin
            win_found = 1'b1;
            win_idx   = kept_idx_reg;
            win_cnt   = kept_cnt_reg;
            win_zone  = kept_zone_reg;
        end
        else if (!strict_reg && can_found_reg)
        begin
            win_found = 1'b1;
            win_idx   = can_idx_reg;
            win_cnt   = can_cnt_reg;
            win_zone  = can_zone_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_node_reg <= win_found ? win_idx : '0;
        end
        if (cmd.out_load)
        begin
            chosen_node_reg   <= res_node_reg;
            group_end_res_reg <= gend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign chosen_node   = chosen_node_reg;
    assign group_end_res = group_end_res_reg;

endmodule

[src/affinity_task_placement.sv]
// Top level of the affinity-aware task placement block.
//
// Input channel (in_valid / in_stall) carries one item per transfer: operation 0
// records a node and its zone, operation 1 places one task of an application.
// Output channel (out_valid / out_stall) carries one result per placement:
// chosen_node (0 when no node qualifies) and group_end_res, a copy of group_end.
// A load item gives no result; the block writes it in the load state, then idles.
// A placement runs from transfer to result through three application table
// reads, a scan of all 64 nodes at one node per cycle through the zone and task
// count memories (filters and least-loaded choice in the same pass), a drain
// state, an update state and the load of the output register.
// One placement is in flight at a time; in_stall is low only while idle, so
// a new item is taken only after the previous item has been completed.
// The output register holds a result while out_stall is high; the block takes
// the next item meanwhile and only waits before loading a following result.
// Reset clears the node presence, task count and application tables at once
// through per-entry valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module affinity_task_placement
    import atp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [NODE_W-1:0] node_index,
    input  logic [ZONE_W-1:0] node_zone,
    input  logic [APP_W-1:0]  app_id,
    input  logic [ZONE_W-1:0] zone_required,
    input  logic [APP_W-1:0]  affine_app,
    input  logic [APP_W-1:0]  anti_app,
    input  logic              anti_strict,
    input  logic              group_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [NODE_W-1:0] chosen_node,
    output logic              group_end_res
);

    dp_cmd_t    cmd;
    dp_status_t status;

    atp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    atp_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .node_index    (node_index),
        .node_zone     (node_zone),
        .app_id        (app_id),
        .zone_required (zone_required),
        .affine_app    (affine_app),
        .anti_app      (anti_app),
        .anti_strict   (anti_strict),
        .group_end     (group_end),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .chosen_node   (chosen_node),
        .group_end_res (group_end_res)
    );

endmodule

[src/atp_checker.sv]
// Port-level checker for the task placement block, bound to the top level.
`timescale 1ns / 1ps

module atp_checker
    import atp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              operation,
    input logic              out_valid,
    input logic              out_stall,
    input logic [NODE_W-1:0] chosen_node,
    input logic              group_end_res
);

    // a load transfer occupies the block for its write cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == OP_LOAD)) |=> in_stall)
        else $error("load transfer not followed by busy cycle");

    // a placement reads the application table before anything else is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (operation == OP_SCHED))
        |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("placement accepted new item during table reads");

    // a new result appears only at the end of a placement, while input is held
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while block was idle");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
        |=> (out_valid && $stable(chosen_node) && $stable(group_end_res)))
        else $error("stalled result changed");

endmodule

bind affinity_task_placement atp_checker u_atp_checker (.*);
